// ----- src/smm_pkg.sv -----
// Shared types and constants for the square matrix multiply core.
// Used by smm_mac and square_matrix_multiply_core; depends on nothing.
package smm_pkg;

    localparam int MODE_W    = 2;
    localparam int IDX_W     = 3;
    localparam int VAL_W     = 16;
    localparam int MUL_W     = 2 * VAL_W;
    localparam int PROD_W    = 35;
    localparam int SIZE_W    = 4;
    localparam int DEF_MAX_N = 8;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Control that travels with the operand pair down the MAC pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

// ----- src/square_matrix_multiply_core.sv -----
// Square matrix multiply core, C = A * B, signed Q1.15 in, exact Q5.30 out.
// A load request writes one operand element when its row and column lie in the store.
// A compute request emits n*n elements; for each, n operand reads pass in order through
// the read register, the product stage, the accumulator and the ready flag, and the
// element then waits for a free output register while the output stalls.
// Reset clears the sequencer and output valid and sets the size to 8; the operand
// memories are not cleared and must be written before use. Depends on smm_pkg, smm_mac.
module square_matrix_multiply_core #(
    parameter int MAX_N = smm_pkg::DEF_MAX_N
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [smm_pkg::MODE_W-1:0]        i_mode,
    input  logic [smm_pkg::IDX_W-1:0]         i_row,
    input  logic [smm_pkg::IDX_W-1:0]         i_col,
    input  logic signed [smm_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [smm_pkg::IDX_W-1:0]         o_out_row,
    output logic [smm_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [smm_pkg::PROD_W-1:0] o_product,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]        i_matrix_size
);
    import smm_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];

    logic [1:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_i, n_i, r_j, n_j, r_k, n_k;
    logic [SIZE_W-1:0]       r_size;
    logic                    r_acc_ready;
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic signed [PROD_W-1:0] r_out_prod;
    logic                    r_out_last;
    logic signed [VAL_W-1:0] r_a_rd, r_b_rd;
    t_mac_ctl                r_rd_ctl;

    logic [SIZE_W-1:0]        n_use;
    logic [IDX_W-1:0]         n_last_idx;
    logic                     in_acc, load_ok, slot_free, emit, mac_done;
    logic [AW-1:0]            wr_addr, rd_addr_a, rd_addr_b;
    logic signed [PROD_W-1:0] mac_acc;
    t_mac_ctl                 rd_ctl;

    // Size zero acts as one, and anything above the store size is clipped.
    always_comb begin
        if (r_size == '0) begin
            n_use = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_N)) begin
            n_use = SIZE_W'(MAX_N);
        end else begin
            n_use = r_size;
        end
    end
    assign n_last_idx = IDX_W'(n_use - SIZE_W'(1));

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign load_ok     = ({1'b0, i_row} < SIZE_W'(MAX_N)) && ({1'b0, i_col} < SIZE_W'(MAX_N));
    assign wr_addr     = AW'(int'(i_row) * MAX_N + int'(i_col));
    assign rd_addr_a   = AW'(int'(r_i) * MAX_N + int'(r_k));
    assign rd_addr_b   = AW'(int'(r_k) * MAX_N + int'(r_j));
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign emit        = (r_state == ST_WAIT) && r_acc_ready && slot_free;

    assign rd_ctl.valid = (r_state == ST_RUN);
    assign rd_ctl.first = (r_k == '0);
    assign rd_ctl.last  = (r_k == n_last_idx);

    always_ff @(posedge i_clk) begin
        if (in_acc && load_ok && i_mode == MODE_LOAD_A) begin
            mem_a[wr_addr] <= i_value;
        end
        if (in_acc && load_ok && i_mode == MODE_LOAD_B) begin
            mem_b[wr_addr] <= i_value;
        end
        r_a_rd <= mem_a[rd_addr_a];
        r_b_rd <= mem_b[rd_addr_b];
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_COMPUTE) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_k == n_last_idx) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (emit) begin
                    n_state = ST_RUN;
                    if (r_j == n_last_idx) begin
                        n_j = '0;
                        if (r_i == n_last_idx) begin
                            n_i     = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_i = r_i + IDX_W'(1);
                        end
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_size      <= SIZE_RESET;
            r_acc_ready <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ctl    <= '0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_rd_ctl <= rd_ctl;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_matrix_size;
            end
            if (mac_done) begin
                r_acc_ready <= 1'b1;
            end else if (emit) begin
                r_acc_ready <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row  <= r_i;
            r_out_col  <= r_j;
            r_out_prod <= mac_acc;
            r_out_last <= (r_i == n_last_idx) && (r_j == n_last_idx);
        end
    end

    smm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (r_a_rd),
        .i_b     (r_b_rd),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_product   = r_out_prod;
    assign o_last      = r_out_last;

    // A finished sum can only appear while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> r_state == ST_WAIT)
        else $error("accumulator finished outside the wait state");

    // The walk never issues reads while an unconsumed sum is held.
    a_run_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> !r_acc_ready)
        else $error("new dot product started over a pending sum");

    // A new result only enters the output register from the wait state.
    a_rose_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_WAIT)
        else $error("output loaded outside the wait state");

    // The final element of a product always lies on the diagonal.
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_row == o_out_col)
        else $error("last flag off the diagonal");

endmodule

// ----- src/smm_mac.sv -----
// Two-stage multiply-accumulate: registered Q2.30 product of Q1.15 operands, then Q5.30 accumulator.
// Depends on smm_pkg for widths and the pipeline control struct.
module smm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smm_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [smm_pkg::VAL_W-1:0]  i_a,
    input  logic signed [smm_pkg::VAL_W-1:0]  i_b,
    output logic signed [smm_pkg::PROD_W-1:0] o_acc,
    output logic                              o_done
);
    import smm_pkg::*;

    t_mac_ctl                  r_p_ctl;
    logic signed [MUL_W-1:0]   r_p;
    logic signed [PROD_W-1:0]  r_acc;
    logic                      r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
            r_done  <= 1'b0;
        end else begin
            r_p_ctl <= i_ctl;
            r_done  <= r_p_ctl.valid && r_p_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
        if (r_p_ctl.valid) begin
            // The first term of a dot product restarts the sum.
            if (r_p_ctl.first) begin
                r_acc <= PROD_W'(r_p);
            end else begin
                r_acc <= r_acc + PROD_W'(r_p);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule
